[rtl/core/cwp_pkg.sv]
// Shared constants, tables and types for the colour wheel pixel core.
package cwp_pkg;

   localparam int COORD_BITS   = 12;
   localparam int HUE_BITS     = 16;
   localparam int CORDIC_STEPS = 16;

   localparam int REG_BITS    = 13;
   localparam int BRIGHT_BITS = 8;
   localparam int FRAC_BITS   = 8;
   localparam int FUNC_BITS   = 2;
   localparam int COLOR_BITS  = 8;
   localparam int RING_HALF   = 8;

   localparam int DIFF_BITS = ((REG_BITS > COORD_BITS + 1) ? REG_BITS : COORD_BITS + 1) + 1;
   localparam int DMAG_BITS = DIFF_BITS - 1;
   localparam int DX_BITS   = DIFF_BITS + FRAC_BITS;
   localparam int PROD_BITS = DMAG_BITS + REG_BITS;
   localparam int NUM_BITS  = PROD_BITS + FRAC_BITS;
   localparam int CW        = NUM_BITS + 3;
   localparam int MAG_BITS  = CW - 1;
   localparam int SPLIT_BITS = (MAG_BITS + 1) / 2;
   localparam int HI_BITS    = MAG_BITS - SPLIT_BITS;
   localparam int GAIN_BITS  = 16;
   localparam int SUM_BITS   = MAG_BITS + GAIN_BITS;
   localparam int L_BITS     = REG_BITS + FRAC_BITS;
   localparam int SAT_BITS   = 16;
   localparam int Q16_BITS   = SAT_BITS + 1;
   localparam int PQ_BITS    = 2 * SAT_BITS + 1;
   localparam int ANG_BITS   = 32;
   localparam int HS_BITS    = HUE_BITS + 3;
   localparam int SECTOR_BITS = 3;
   localparam int COMP_BITS  = BRIGHT_BITS + Q16_BITS + 1;

   localparam int REQ_DATA_BITS = ((FUNC_BITS + 2 * COORD_BITS + 7) / 8) * 8;
   localparam int ITEM_BITS     = 3 * COLOR_BITS + 1;
   localparam int RSP_DATA_BITS = ((ITEM_BITS + 7) / 8) * 8;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [GAIN_BITS-1:0] INV_GAIN  = 16'd39796;
   localparam logic [Q16_BITS-1:0]  ONE_Q16   = Q16_BITS'(1) << SAT_BITS;
   localparam logic [ANG_BITS-1:0]  HALF_TURN = 32'h8000_0000;
   localparam logic [COMP_BITS-1:0] COMP_ROUND = COMP_BITS'(1) << (SAT_BITS - 1);
   localparam logic [BRIGHT_BITS-1:0] FULL_VALUE = '1;

   localparam logic [FUNC_BITS-1:0] FUNC_RENDER     = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_FULL       = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_BRIGHT     = 2'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_BRIGHT_ALT = 2'd3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_RADIUS_X = 3'd2,
      CSR_RADIUS_Y = 3'd3,
      CSR_BRIGHT   = 3'd4
   } cwp_csr_type;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      logic                 zero;
   } cwp_side_type;

   localparam logic [ANG_BITS-1:0] ATAN_TURNS [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

endpackage

[rtl/core/cwp_cordic.sv]
// Pipelined vectoring CORDIC, one rotation per register stage.
module cwp_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [cwp_pkg::CW-1:0]     in_x,
   input  logic signed [cwp_pkg::CW-1:0]     in_y,
   input  logic [cwp_pkg::ANG_BITS-1:0]      in_ang,
   input  cwp_pkg::cwp_side_type             in_side,
   output logic                              out_valid,
   output logic signed [cwp_pkg::CW-1:0]     out_x,
   output logic [cwp_pkg::ANG_BITS-1:0]      out_ang,
   output cwp_pkg::cwp_side_type             out_side
);
   import cwp_pkg::*;

   logic                 valid_ff [1:CORDIC_STEPS];
   logic signed [CW-1:0] x_ff     [1:CORDIC_STEPS];
   logic signed [CW-1:0] y_ff     [1:CORDIC_STEPS];
   logic [ANG_BITS-1:0]  ang_ff   [1:CORDIC_STEPS];
   cwp_side_type         side_ff  [1:CORDIC_STEPS];

   for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_stage
      logic                 vp;
      logic signed [CW-1:0] xp;
      logic signed [CW-1:0] yp;
      logic [ANG_BITS-1:0]  ap;
      cwp_side_type         sp;
      logic                 pos;
      logic signed [CW-1:0] x_in;
      logic [ANG_BITS-1:0]  ang_in;

      if (k == 1) begin : g_first
         assign vp = in_valid;
         assign xp = in_x;
         assign yp = in_y;
         assign ap = in_ang;
         assign sp = in_side;
      end else begin : g_next
         assign vp = valid_ff[k-1];
         assign xp = x_ff[k-1];
         assign yp = y_ff[k-1];
         assign ap = ang_ff[k-1];
         assign sp = side_ff[k-1];
      end

      assign pos    = (yp > 0);
      assign x_in   = pos ? (xp + (yp >>> (k - 1))) : (xp - (yp >>> (k - 1)));
      assign ang_in = pos ? (ap + ATAN_TURNS[k-1]) : (ap - ATAN_TURNS[k-1]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]    <= x_in;
            ang_ff[k]  <= ang_in;
            side_ff[k] <= sp;
         end
      end

      if (k < CORDIC_STEPS) begin : g_y
         logic signed [CW-1:0] y_in;
         assign y_in = pos ? (yp - (xp >>> (k - 1))) : (yp + (xp >>> (k - 1)));
         always_ff @(posedge clock) begin
            if (en) begin
               y_ff[k] <= y_in;
            end
         end
      end else begin : g_no_y
         always_ff @(posedge clock) begin
            if (en) begin
               y_ff[k] <= yp;
            end
         end
      end
   end

   assign out_valid = valid_ff[CORDIC_STEPS];
   assign out_x     = x_ff[CORDIC_STEPS];
   assign out_ang   = ang_ff[CORDIC_STEPS];
   assign out_side  = side_ff[CORDIC_STEPS];

endmodule

[rtl/core/color_wheel_pixel_to_rgb_core.sv]
// Top level of the colour wheel core: pixel position in, RGB colour of the wheel out.
//
//  Channel | Direction | Handshake                 | Content
//  req     | in        | req_tvalid / req_tready   | func, pos_x, pos_y
//  rsp     | out       | rsp_tvalid / rsp_tready   | red, green, blue, inside_res
//  csr     | in        | csr_valid / csr_ready     | register index and write data
//
// One item is taken every cycle while the output queue has room; a result is offered once it has
// passed the bit-per-stage y scaling divider, the CORDIC stages and the saturation divider.
// Reset clears all valid bits, the output queue and loads the register defaults.
// A two-entry output queue lets the pipeline keep taking items while one result waits;
// the whole pipeline holds only when that queue is full.
module color_wheel_pixel_to_rgb_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // func, pos_x, pos_y from the lowest bit up
   input  logic [cwp_pkg::REQ_DATA_BITS-1:0]      req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // red, green, blue, inside_res from the lowest bit up
   output logic [cwp_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cwp_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [cwp_pkg::REG_BITS-1:0]           csr_data
);
   import cwp_pkg::*;

   // Configuration registers
   logic [REG_BITS-1:0]    cx_ff, cy_ff, rx_ff, ry_ff;
   logic [BRIGHT_BITS-1:0] bright_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= REG_BITS'(50);
         cy_ff     <= REG_BITS'(50);
         rx_ff     <= REG_BITS'(50);
         ry_ff     <= REG_BITS'(50);
         bright_ff <= FULL_VALUE;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTER_X: cx_ff     <= csr_data;
            CSR_CENTER_Y: cy_ff     <= csr_data;
            CSR_RADIUS_X: rx_ff     <= csr_data;
            CSR_RADIUS_Y: ry_ff     <= csr_data;
            CSR_BRIGHT:   bright_ff <= csr_data[BRIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Values derived from the registers
   logic [REG_BITS-1:0]   div_y;
   logic signed [REG_BITS:0] inner;
   logic                  inner_neg;
   logic [REG_BITS:0]     inner_abs;
   logic [L_BITS-1:0]     inner_l;

   assign div_y     = (ry_ff == '0) ? REG_BITS'(1) : ry_ff;
   assign inner     = $signed((REG_BITS + 1)'(rx_ff)) - (REG_BITS + 1)'(RING_HALF);
   assign inner_neg = inner[REG_BITS];
   assign inner_abs = inner_neg ? -inner : inner;
   assign inner_l   = {inner_abs[REG_BITS-1:0], FRAC_BITS'(0)};

   // Output queue and pipeline enable
   logic [ITEM_BITS-1:0] fifo_ff [2];
   logic                 wr_ff, rd_ff;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 en, push, pop;
   logic [ITEM_BITS-1:0] item_in;

   assign en         = (cnt_ff != 2'd2);
   assign req_tready = en;

   // Stage 1: offsets from the centre
   logic [FUNC_BITS-1:0]        in_func;
   logic [COORD_BITS-1:0]       in_px, in_py;
   logic [DIFF_BITS-1:0]        dxd_in, dy2_in, dy2_abs;

   assign in_func = req_tdata[FUNC_BITS-1:0];
   assign in_px   = req_tdata[FUNC_BITS +: COORD_BITS];
   assign in_py   = req_tdata[FUNC_BITS + COORD_BITS +: COORD_BITS];
   assign dxd_in  = DIFF_BITS'(cx_ff) - DIFF_BITS'({in_px, 1'b0});
   assign dy2_in  = DIFF_BITS'({in_py, 1'b0}) - DIFF_BITS'(cy_ff);
   assign dy2_abs = dy2_in[DIFF_BITS-1] ? -dy2_in : dy2_in;

   logic                  s1_valid_ff;
   logic [FUNC_BITS-1:0]  s1_func_ff;
   logic [DX_BITS-1:0]    s1_dx_ff;
   logic [DMAG_BITS-1:0]  s1_dmag_ff;
   logic                  s1_dneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_func_ff <= in_func;
         s1_dx_ff   <= {dxd_in, FRAC_BITS'(0)};
         s1_dmag_ff <= dy2_abs[DMAG_BITS-1:0];
         s1_dneg_ff <= dy2_in[DIFF_BITS-1];
      end
   end

   // Stage 2: numerator of the y scaling
   logic                  s2_valid_ff;
   logic [FUNC_BITS-1:0]  s2_func_ff;
   logic [DX_BITS-1:0]    s2_dx_ff;
   logic                  s2_dneg_ff;
   logic [PROD_BITS-1:0]  s2_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_func_ff <= s1_func_ff;
         s2_dx_ff   <= s1_dx_ff;
         s2_dneg_ff <= s1_dneg_ff;
         s2_prod_ff <= PROD_BITS'(s1_dmag_ff) * PROD_BITS'(rx_ff);
      end
   end

   // Y scaling divider, one quotient bit per stage
   logic                 d1_valid_ff [1:NUM_BITS];
   logic [FUNC_BITS-1:0] d1_func_ff  [1:NUM_BITS];
   logic [DX_BITS-1:0]   d1_dx_ff    [1:NUM_BITS];
   logic                 d1_dneg_ff  [1:NUM_BITS];
   logic [REG_BITS-1:0]  d1_rem_ff   [1:NUM_BITS];
   logic [NUM_BITS-1:0]  d1_work_ff  [1:NUM_BITS];

   for (genvar k = 1; k <= NUM_BITS; k++) begin : g_div_y
      logic                 vp;
      logic [FUNC_BITS-1:0] fp;
      logic [DX_BITS-1:0]   xp;
      logic                 np;
      logic [REG_BITS-1:0]  rp;
      logic [NUM_BITS-1:0]  wp;
      logic [REG_BITS:0]    rem_sh, rem_sub;
      logic                 ge;

      if (k == 1) begin : g_first
         assign vp = s2_valid_ff;
         assign fp = s2_func_ff;
         assign xp = s2_dx_ff;
         assign np = s2_dneg_ff;
         assign rp = '0;
         assign wp = {s2_prod_ff, FRAC_BITS'(0)};
      end else begin : g_next
         assign vp = d1_valid_ff[k-1];
         assign fp = d1_func_ff[k-1];
         assign xp = d1_dx_ff[k-1];
         assign np = d1_dneg_ff[k-1];
         assign rp = d1_rem_ff[k-1];
         assign wp = d1_work_ff[k-1];
      end

      assign rem_sh  = {rp, wp[NUM_BITS-1]};
      assign ge      = (rem_sh >= {1'b0, div_y});
      assign rem_sub = ge ? (rem_sh - {1'b0, div_y}) : rem_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            d1_valid_ff[k] <= 1'b0;
         end else if (en) begin
            d1_valid_ff[k] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d1_func_ff[k] <= fp;
            d1_dx_ff[k]   <= xp;
            d1_dneg_ff[k] <= np;
            d1_rem_ff[k]  <= rem_sub[REG_BITS-1:0];
            d1_work_ff[k] <= {wp[NUM_BITS-2:0], ge};
         end
      end
   end

   // Stage 3: fold into the right half plane for the CORDIC
   logic [NUM_BITS-1:0]  q_y;
   logic                 flip;
   logic signed [CW-1:0] dx_ext;

   assign q_y    = d1_work_ff[NUM_BITS];
   assign flip   = d1_dneg_ff[NUM_BITS] && (q_y != '0);
   assign dx_ext = CW'($signed(d1_dx_ff[NUM_BITS]));

   logic                 s3_valid_ff;
   logic signed [CW-1:0] s3_x_ff, s3_y_ff;
   logic [ANG_BITS-1:0]  s3_ang_ff;
   cwp_side_type         s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= d1_valid_ff[NUM_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_x_ff         <= $signed(CW'(q_y));
         s3_y_ff         <= flip ? -dx_ext : dx_ext;
         s3_ang_ff       <= flip ? HALF_TURN : '0;
         s3_side_ff.func <= d1_func_ff[NUM_BITS];
         s3_side_ff.zero <= (d1_dx_ff[NUM_BITS] == '0) && (q_y == '0);
      end
   end

   logic                 c_valid;
   logic signed [CW-1:0] c_x;
   logic [ANG_BITS-1:0]  c_ang;
   cwp_side_type         c_side;

   cwp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_x      (s3_x_ff),
      .in_y      (s3_y_ff),
      .in_ang    (s3_ang_ff),
      .in_side   (s3_side_ff),
      .out_valid (c_valid),
      .out_x     (c_x),
      .out_ang   (c_ang),
      .out_side  (c_side)
   );

   // M1: gain correction partial products and hue sector
   logic [MAG_BITS-1:0]    xc;
   logic [ANG_BITS-1:0]    hue32;
   logic [HUE_BITS-1:0]    hue;
   logic [HS_BITS-1:0]     hs;
   logic [HUE_BITS+15:0]   f_wide;

   assign xc     = c_x[CW-1] ? '0 : c_x[MAG_BITS-1:0];
   assign hue32  = c_side.zero ? HALF_TURN : (c_ang + HALF_TURN);
   assign hue    = hue32[ANG_BITS-1 -: HUE_BITS];
   assign hs     = (HS_BITS'(hue) << 2) + (HS_BITS'(hue) << 1);
   assign f_wide = {hs[HUE_BITS-1:0], 16'd0} >> HUE_BITS;

   logic                         m1_valid_ff;
   logic [FUNC_BITS-1:0]         m1_func_ff;
   logic [SECTOR_BITS-1:0]       m1_sector_ff;
   logic [SAT_BITS-1:0]          m1_f_ff;
   logic [SPLIT_BITS+GAIN_BITS-1:0] m1_plo_ff;
   logic [HI_BITS+GAIN_BITS-1:0]    m1_phi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_func_ff   <= c_side.func;
         m1_sector_ff <= hs[HS_BITS-1 -: SECTOR_BITS];
         m1_f_ff      <= f_wide[SAT_BITS-1:0];
         m1_plo_ff    <= (SPLIT_BITS + GAIN_BITS)'(xc[SPLIT_BITS-1:0]) *
                         (SPLIT_BITS + GAIN_BITS)'(INV_GAIN);
         m1_phi_ff    <= (HI_BITS + GAIN_BITS)'(xc[MAG_BITS-1:SPLIT_BITS]) *
                         (HI_BITS + GAIN_BITS)'(INV_GAIN);
      end
   end

   // M2: distance
   logic [SUM_BITS-1:0] gain_sum;

   assign gain_sum = SUM_BITS'({m1_phi_ff, SPLIT_BITS'(0)}) + SUM_BITS'(m1_plo_ff);

   logic                   m2_valid_ff;
   logic [FUNC_BITS-1:0]   m2_func_ff;
   logic [SECTOR_BITS-1:0] m2_sector_ff;
   logic [SAT_BITS-1:0]    m2_f_ff;
   logic [MAG_BITS-1:0]    m2_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (en) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_func_ff   <= m1_func_ff;
         m2_sector_ff <= m1_sector_ff;
         m2_f_ff      <= m1_f_ff;
         m2_r_ff      <= gain_sum[SUM_BITS-1:GAIN_BITS];
      end
   end

   // V0: ring test and saturation divider set-up
   logic v_full;

   assign v_full = (inner_l == '0) || (m2_r_ff >= MAG_BITS'(inner_l));

   logic                   v0_valid_ff;
   logic [FUNC_BITS-1:0]   v0_func_ff;
   logic [SECTOR_BITS-1:0] v0_sector_ff;
   logic [SAT_BITS-1:0]    v0_f_ff;
   logic                   v0_kill_ff, v0_inside_ff, v0_full_ff;
   logic [L_BITS-1:0]      v0_rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_valid_ff <= 1'b0;
      end else if (en) begin
         v0_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v0_func_ff   <= m2_func_ff;
         v0_sector_ff <= m2_sector_ff;
         v0_f_ff      <= m2_f_ff;
         v0_kill_ff   <= (m2_func_ff == FUNC_RENDER) &&
                         (inner_neg || (m2_r_ff > MAG_BITS'(inner_l)));
         v0_inside_ff <= (m2_func_ff != FUNC_RENDER) ||
                         (m2_r_ff < MAG_BITS'({rx_ff, FRAC_BITS'(0)}));
         v0_full_ff   <= v_full;
         v0_rem_ff    <= v_full ? '0 : m2_r_ff[L_BITS-1:0];
      end
   end

   // Saturation divider, one quotient bit per stage
   logic                   d2_valid_ff  [1:SAT_BITS];
   logic [FUNC_BITS-1:0]   d2_func_ff   [1:SAT_BITS];
   logic [SECTOR_BITS-1:0] d2_sector_ff [1:SAT_BITS];
   logic [SAT_BITS-1:0]    d2_f_ff      [1:SAT_BITS];
   logic                   d2_kill_ff   [1:SAT_BITS];
   logic                   d2_inside_ff [1:SAT_BITS];
   logic                   d2_full_ff   [1:SAT_BITS];
   logic [L_BITS-1:0]      d2_rem_ff    [1:SAT_BITS];
   logic [SAT_BITS-1:0]    d2_quo_ff    [1:SAT_BITS];

   for (genvar k = 1; k <= SAT_BITS; k++) begin : g_div_s
      logic                   vp;
      logic [FUNC_BITS-1:0]   fp;
      logic [SECTOR_BITS-1:0] sp;
      logic [SAT_BITS-1:0]    hp;
      logic                   kp, ip, up;
      logic [L_BITS-1:0]      rp;
      logic [SAT_BITS-1:0]    qp;
      logic [L_BITS:0]        rem_sh, rem_sub;
      logic                   ge;

      if (k == 1) begin : g_first
         assign vp = v0_valid_ff;
         assign fp = v0_func_ff;
         assign sp = v0_sector_ff;
         assign hp = v0_f_ff;
         assign kp = v0_kill_ff;
         assign ip = v0_inside_ff;
         assign up = v0_full_ff;
         assign rp = v0_rem_ff;
         assign qp = '0;
      end else begin : g_next
         assign vp = d2_valid_ff[k-1];
         assign fp = d2_func_ff[k-1];
         assign sp = d2_sector_ff[k-1];
         assign hp = d2_f_ff[k-1];
         assign kp = d2_kill_ff[k-1];
         assign ip = d2_inside_ff[k-1];
         assign up = d2_full_ff[k-1];
         assign rp = d2_rem_ff[k-1];
         assign qp = d2_quo_ff[k-1];
      end

      assign rem_sh  = {rp, 1'b0};
      assign ge      = (rem_sh >= {1'b0, inner_l});
      assign rem_sub = ge ? (rem_sh - {1'b0, inner_l}) : rem_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            d2_valid_ff[k] <= 1'b0;
         end else if (en) begin
            d2_valid_ff[k] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d2_func_ff[k]   <= fp;
            d2_sector_ff[k] <= sp;
            d2_f_ff[k]      <= hp;
            d2_kill_ff[k]   <= kp;
            d2_inside_ff[k] <= ip;
            d2_full_ff[k]   <= up;
            d2_rem_ff[k]    <= rem_sub[L_BITS-1:0];
            d2_quo_ff[k]    <= {qp[SAT_BITS-2:0], ge};
         end
      end
   end

   // P1: saturation times hue fraction
   logic [Q16_BITS-1:0] sat;
   logic [Q16_BITS-1:0] f_comp;

   assign sat = d2_full_ff[SAT_BITS] ? ONE_Q16 :
                (d2_quo_ff[SAT_BITS] == '0) ? Q16_BITS'(1) :
                Q16_BITS'(d2_quo_ff[SAT_BITS]);
   assign f_comp = ONE_Q16 - Q16_BITS'(d2_f_ff[SAT_BITS]);

   logic                   p1_valid_ff;
   logic [FUNC_BITS-1:0]   p1_func_ff;
   logic [SECTOR_BITS-1:0] p1_sector_ff;
   logic                   p1_kill_ff, p1_inside_ff;
   logic [Q16_BITS-1:0]    p1_s_ff;
   logic [PQ_BITS-1:0]     p1_sf_ff, p1_sg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= d2_valid_ff[SAT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_func_ff   <= d2_func_ff[SAT_BITS];
         p1_sector_ff <= d2_sector_ff[SAT_BITS];
         p1_kill_ff   <= d2_kill_ff[SAT_BITS];
         p1_inside_ff <= d2_inside_ff[SAT_BITS];
         p1_s_ff      <= sat;
         p1_sf_ff     <= PQ_BITS'(sat) * PQ_BITS'(d2_f_ff[SAT_BITS]);
         p1_sg_ff     <= PQ_BITS'(sat) * PQ_BITS'(f_comp);
      end
   end

   // P2: sector rule
   logic [Q16_BITS-1:0] term_w, term_q, term_t;
   logic [Q16_BITS-1:0] red_in, green_in, blue_in;

   assign term_w = ONE_Q16 - p1_s_ff;
   assign term_q = ONE_Q16 - p1_sf_ff[PQ_BITS-1:SAT_BITS];
   assign term_t = ONE_Q16 - p1_sg_ff[PQ_BITS-1:SAT_BITS];

   always_comb begin
      red_in   = ONE_Q16;
      green_in = ONE_Q16;
      blue_in  = ONE_Q16;
      case (p1_sector_ff)
         3'd0: begin
            green_in = term_t;
            blue_in  = term_w;
         end
         3'd1: begin
            red_in  = term_q;
            blue_in = term_w;
         end
         3'd2: begin
            red_in  = term_w;
            blue_in = term_t;
         end
         3'd3: begin
            red_in   = term_w;
            green_in = term_q;
         end
         3'd4: begin
            red_in   = term_t;
            green_in = term_w;
         end
         default: begin
            green_in = term_w;
            blue_in  = term_q;
         end
      endcase
   end

   logic                 p2_valid_ff;
   logic [FUNC_BITS-1:0] p2_func_ff;
   logic                 p2_kill_ff, p2_inside_ff;
   logic [Q16_BITS-1:0]  p2_r_ff, p2_g_ff, p2_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_func_ff   <= p1_func_ff;
         p2_kill_ff   <= p1_kill_ff;
         p2_inside_ff <= p1_inside_ff;
         p2_r_ff      <= red_in;
         p2_g_ff      <= green_in;
         p2_b_ff      <= blue_in;
      end
   end

   // Scaling by the value and rounding into the output queue
   logic [BRIGHT_BITS-1:0] value;
   logic [COMP_BITS-1:0]   red_p, green_p, blue_p;
   logic [COLOR_BITS-1:0]  red_c, green_c, blue_c;

   assign value   = (p2_func_ff == FUNC_RENDER || p2_func_ff == FUNC_FULL) ?
                    FULL_VALUE : bright_ff;
   assign red_p   = COMP_BITS'(value) * COMP_BITS'(p2_r_ff) + COMP_ROUND;
   assign green_p = COMP_BITS'(value) * COMP_BITS'(p2_g_ff) + COMP_ROUND;
   assign blue_p  = COMP_BITS'(value) * COMP_BITS'(p2_b_ff) + COMP_ROUND;
   assign red_c   = p2_kill_ff ? '0 : red_p[SAT_BITS +: COLOR_BITS];
   assign green_c = p2_kill_ff ? '0 : green_p[SAT_BITS +: COLOR_BITS];
   assign blue_c  = p2_kill_ff ? '0 : blue_p[SAT_BITS +: COLOR_BITS];
   assign item_in = {p2_inside_ff, blue_c, green_c, red_c};

   assign push   = en && p2_valid_ff;
   assign pop    = rsp_tvalid && rsp_tready;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ff] <= item_in;
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = RSP_DATA_BITS'(fifo_ff[rd_ff]);

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output queue count out of range");

   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_tready == (cnt_ff != 2'd2))
      else $error("input ready does not follow queue room");

   a_outside_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[3*COLOR_BITS] |-> rsp_tdata[3*COLOR_BITS-1:0] == '0)
      else $error("outside point is not black");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> cnt_ff != 2'd2)
      else $error("item pushed into a full output queue");

endmodule

[bench/color_wheel_pixel_to_rgb_core_tb.sv]
// Self-checking testbench for the colour wheel pixel core with a built-in colour predictor.
module color_wheel_pixel_to_rgb_core_tb;
   import cwp_pkg::*;

   localparam int QUIET_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;
   localparam int PIXEL_BITS = FUNC_BITS + 2 * COORD_BITS;

   typedef struct packed {
      logic [COORD_BITS-1:0] pos_y;
      logic [COORD_BITS-1:0] pos_x;
      logic [FUNC_BITS-1:0]  func;
   } pixel_type;

   typedef struct packed {
      logic                  inside_res;
      logic [COLOR_BITS-1:0] blue;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] red;
   } colour_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [REG_BITS-1:0] csr_data = '0;

   pixel_type  pending_pixels[$];
   colour_type expected_colours[$];
   int errors = 0;
   int quiet_cycles = 0;
   bit sender_on = 1'b0;
   int burst_left = 0, gap_left = 0;
   int hold_off = 0;
   int stall_phase = 0;

   longint wheel_cx, wheel_cy, wheel_rx, wheel_ry, wheel_bright;

   color_wheel_pixel_to_rgb_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint floor_shift(longint v, int n);
      return v >= 0 ? (v >>> n) : (-1 - ((-1 - v) >>> n));
   endfunction

   function automatic logic [7:0] shade(longint b, longint x);
      longint p;
      p = (b * x + 32768) >>> 16;
      return p[7:0];
   endfunction

   function automatic colour_type wheel_colour(pixel_type p);
      colour_type c;
      longint ryd, dx, dy2, mag, dy, xv, yv, sx, sy, r, inner, l, s, hue, hs, sector, f;
      longint w, q, t, rr, gg, bb, b;
      logic [31:0] ang, hue32;
      ryd = wheel_ry != 0 ? wheel_ry : 1;
      dx = (wheel_cx - 2 * longint'(p.pos_x)) * 256;
      dy2 = 2 * longint'(p.pos_y) - wheel_cy;
      mag = (dy2 < 0 ? -dy2 : dy2) * wheel_rx * 256 / ryd;
      dy = dy2 < 0 ? -mag : mag;
      xv = dy;
      yv = dx;
      ang = 0;
      if (xv < 0) begin
         xv = -xv;
         yv = -yv;
         ang = HALF_TURN;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         sx = floor_shift(yv, i);
         sy = floor_shift(xv, i);
         if (yv > 0) begin
            xv += sx; yv -= sy; ang += ATAN_TURNS[i];
         end else begin
            xv -= sx; yv += sy; ang -= ATAN_TURNS[i];
         end
      end
      r = ((xv < 0 ? 0 : xv) * 39796) >>> 16;
      hue32 = (dx == 0 && dy == 0) ? HALF_TURN : ang + HALF_TURN;
      inner = wheel_rx - RING_HALF;
      c = '0;
      c.inside_res = 1'b1;
      if (p.func == FUNC_RENDER && r > inner * 256) begin
         c.inside_res = r < wheel_rx * 256;
         return c;
      end
      l = (inner < 0 ? -inner : inner) * 256;
      s = (l == 0 || r >= l) ? 65536 : (r << 16) / l;
      if (s == 0) s = 1;
      hue = longint'(hue32 >> (32 - HUE_BITS));
      hs = hue * 6;
      sector = hs >>> HUE_BITS;
      f = hs & ((longint'(1) << HUE_BITS) - 1);
      f = f >>> (HUE_BITS - 16);
      w = 65536 - s;
      q = 65536 - ((s * f) >>> 16);
      t = 65536 - ((s * (65536 - f)) >>> 16);
      rr = 65536; gg = 65536; bb = 65536;
      case (sector)
         0: begin gg = t; bb = w; end
         1: begin rr = q; bb = w; end
         2: begin rr = w; bb = t; end
         3: begin rr = w; gg = q; end
         4: begin rr = t; gg = w; end
         default: begin gg = w; bb = q; end
      endcase
      b = p.func[1] ? wheel_bright : 255;
      c.red = shade(b, rr);
      c.green = shade(b, gg);
      c.blue = shade(b, bb);
      return c;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // The sender alternates bursts and gaps; it is held while the pause flag is set.
   bit sender_paused = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (!req_tvalid || req_tready) begin
            if (req_tvalid && req_tready) begin
               expected_colours.push_back(
                  wheel_colour(pixel_type'(req_tdata[PIXEL_BITS-1:0])));
            end
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_pixels.size() > 0 && !sender_paused) begin
               req_tvalid <= 1'b1;
               req_tdata <= REQ_DATA_BITS'(pending_pixels.pop_front());
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            colour_type got, want;
            got = colour_type'(rsp_tdata[ITEM_BITS-1:0]);
            if (expected_colours.size() == 0) begin
               report_mismatch("unexpected item", 0, 0);
            end else begin
               want = expected_colours.pop_front();
               if (got.red !== want.red) report_mismatch("red", got.red, want.red);
               if (got.green !== want.green) report_mismatch("green", got.green, want.green);
               if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
               if (got.inside_res !== want.inside_res)
                  report_mismatch("inside_res", got.inside_res, want.inside_res);
            end
         end
         stall_phase = (stall_phase + 1) % 23;
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (stall_phase < 12) ? 1'b1 : ($urandom_range(0, 3) != 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("color_wheel_pixel_to_rgb_core_tb NOT OK");
            $finish;
         end
      end
   end

   task automatic write_register(cwp_csr_type idx, longint value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[REG_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CENTER_X: wheel_cx = value & 13'h1FFF;
         CSR_CENTER_Y: wheel_cy = value & 13'h1FFF;
         CSR_RADIUS_X: wheel_rx = value & 13'h1FFF;
         CSR_RADIUS_Y: wheel_ry = value & 13'h1FFF;
         default: wheel_bright = value & 8'hFF;
      endcase
   endtask

   task automatic drain;
      while (pending_pixels.size() > 0 || req_tvalid || expected_colours.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_pixel(int func, int x, int y);
      pixel_type p;
      p.func = FUNC_BITS'(func);
      p.pos_x = COORD_BITS'(x);
      p.pos_y = COORD_BITS'(y);
      pending_pixels.push_back(p);
   endtask

   // Points mostly near the wheel so that hue, saturation and ring all get exercised.
   task automatic add_random(int count);
      int cx, cy, span;
      for (int i = 0; i < count; i++) begin
         cx = int'(wheel_cx / 2);
         cy = int'(wheel_cy / 2);
         span = int'(wheel_rx / 2 + 12);
         if ($urandom_range(0, 4) == 0) begin
            add_pixel($urandom_range(0, 3), $urandom_range(0, 4095), $urandom_range(0, 4095));
         end else begin
            add_pixel($urandom_range(0, 3),
                      (cx + $urandom_range(0, 2 * span) - span) & 12'hFFF,
                      (cy + $urandom_range(0, 2 * span) - span) & 12'hFFF);
         end
      end
   endtask

   initial begin
      wheel_cx = 50; wheel_cy = 50; wheel_rx = 50; wheel_ry = 50; wheel_bright = 255;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: centre, ring, outside, every function, coordinate extremes.
      add_pixel(FUNC_RENDER, 25, 25);
      add_pixel(FUNC_FULL, 25, 25);
      add_pixel(FUNC_BRIGHT, 25, 25);
      add_pixel(FUNC_BRIGHT_ALT, 25, 25);
      add_pixel(FUNC_RENDER, 48, 25);
      add_pixel(FUNC_RENDER, 25, 48);
      add_pixel(FUNC_RENDER, 50, 25);
      add_pixel(FUNC_RENDER, 0, 25);
      add_pixel(FUNC_RENDER, 25, 0);
      add_pixel(FUNC_FULL, 4095, 4095);
      add_pixel(FUNC_RENDER, 4095, 0);
      add_pixel(FUNC_BRIGHT, 0, 4095);
      add_pixel(FUNC_FULL, 0, 25);
      add_pixel(FUNC_FULL, 25, 10);
      add_pixel(FUNC_FULL, 40, 40);
      add_pixel(FUNC_FULL, 10, 40);
      add_pixel(FUNC_FULL, 26, 25);
      add_pixel(FUNC_RENDER, 30, 20);
      drain();

      write_register(CSR_BRIGHT, 0);
      write_register(CSR_RADIUS_X, 10);
      write_register(CSR_RADIUS_Y, 8191);
      add_pixel(FUNC_BRIGHT, 25, 25);
      add_pixel(FUNC_RENDER, 27, 25);
      add_pixel(FUNC_FULL, 20, 4095);
      add_random(60);
      drain();

      // Inner radius of eight, then a large wheel at the far corner.
      write_register(CSR_RADIUS_X, 16);
      write_register(CSR_RADIUS_Y, 10);
      write_register(CSR_BRIGHT, 128);
      add_random(60);
      drain();
      write_register(CSR_CENTER_X, 8191);
      write_register(CSR_CENTER_Y, 8191);
      write_register(CSR_RADIUS_X, 8191);
      write_register(CSR_RADIUS_Y, 8191);
      write_register(CSR_BRIGHT, 255);
      add_random(60);
      add_pixel(FUNC_RENDER, 0, 0);
      add_pixel(FUNC_FULL, 4095, 4095);
      drain();

      write_register(CSR_CENTER_X, 0);
      write_register(CSR_CENTER_Y, 0);
      write_register(CSR_RADIUS_X, 200);
      write_register(CSR_RADIUS_Y, 90);
      write_register(CSR_BRIGHT, 77);
      hold_off = 400;
      add_random(150);
      drain();

      write_register(CSR_CENTER_X, $urandom_range(0, 8191));
      write_register(CSR_CENTER_Y, $urandom_range(0, 8191));
      write_register(CSR_RADIUS_X, $urandom_range(10, 300));
      write_register(CSR_RADIUS_Y, $urandom_range(10, 300));
      write_register(CSR_BRIGHT, $urandom_range(0, 255));
      add_random(60);
      drain();
      add_random(30);
      while (pending_pixels.size() > 0) @(posedge clock);

      // Second half of the random items waits until everything else has come back.
      sender_paused = 1'b1;
      add_random(30);
      while (req_tvalid || expected_colours.size() > 0) @(posedge clock);
      sender_paused = 1'b0;
      drain();

      if (errors == 0) begin
         $display("color_wheel_pixel_to_rgb_core_tb OK");
      end else begin
         $display("color_wheel_pixel_to_rgb_core_tb NOT OK");
      end
      $finish;
   end

endmodule
